FILE: sv/skyline_rect_packer_top_assert.svh
// assertion macros for the skyline rectangle packer
`ifndef SKYLINE_RECT_PACKER_TOP_ASSERT_SVH
`define SKYLINE_RECT_PACKER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define SRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/srp_pkg.sv
// shared types and constants of the skyline rectangle packer
package srp_pkg;

  localparam int DIM_W  = 13;
  localparam int POS_W  = 12;
  localparam int AREA_W = 25;
  localparam int PROD_W = 2 * DIM_W;
  localparam int CFG_IDX_W = 2;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [AREA_W-1:0] area_t;

  localparam dim_t  RESET_DIM = 13'd512;
  localparam area_t AREA_MAX  = '1;

  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_W = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_H = 2'd1;

  typedef enum logic [1:0] {
    ST_PLACED = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_ZERO   = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // one skyline segment
  typedef struct packed {
    logic v;
    dim_t x;
    dim_t top;
    dim_t span;
  } seg_t;

  // a candidate left edge walking along the chain
  typedef struct packed {
    logic               v;
    logic               act;
    logic               rneed;
    logic               trim;
    logic               rv;
    logic signed [DIM_W:0] left;
    dim_t               y;
    dim_t               kx;
    dim_t               kspan;
    logic               pv;
    dim_t               ptop;
    dim_t               rtop;
    dim_t               rspan;
    dim_t               cov;
  } probe_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_LAUNCH,
    OP_SCAN,
    OP_INSERT,
    OP_EDIT,
    OP_SWAP_EVEN,
    OP_SWAP_ODD
  } cell_op_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t op;
    dim_t     w;
    dim_t     h;
    dim_t     aw;
    dim_t     ah;
    dim_t     bx;
    dim_t     newtop;
    dim_t     edge_x;
    dim_t     rspan;
    logic     lmerge;
    logic     rmerge;
  } ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_SCAN,
    S_INSERT,
    S_EDIT,
    S_COMPACT,
    S_DONE
  } state_t;

endpackage

FILE: sv/srp_cell.sv
// one skyline cell: a segment, its probe slot and the local edit rules
module srp_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  srp_pkg::ctl_t   ctl,
  input  srp_pkg::seg_t   seg_l,
  input  srp_pkg::seg_t   seg_r,
  output srp_pkg::seg_t   seg_o,
  input  srp_pkg::probe_t prb_i,
  output srp_pkg::probe_t prb_o
);
  import srp_pkg::*;

  seg_t   seg_r_r, seg_nxt;
  probe_t prb_r, prb_nxt, prb_run, prb_init;

  logic [DIM_W:0]        ymax, yh, end_x, xw;
  logic signed [DIM_W:0] lnew;
  dim_t                  sum_w;
  logic                  left_member;

  // walk one step of the resting height search over this segment
  always_comb begin
    prb_run = prb_r;
    ymax    = '0;
    yh      = '0;
    lnew    = '0;
    if (prb_r.v && prb_r.act) begin
      if (!seg_r_r.v) begin
        prb_run.v = 1'b0;
      end else begin
        ymax = (seg_r_r.top > prb_r.y) ? {1'b0, seg_r_r.top} : {1'b0, prb_r.y};
        yh   = ymax + {1'b0, ctl.h};
        if (yh > {1'b0, ctl.ah}) begin
          prb_run.v = 1'b0;
        end else begin
          prb_run.y    = ymax[DIM_W-1:0];
          lnew         = prb_r.left - $signed({1'b0, seg_r_r.span});
          prb_run.left = lnew;
          prb_run.cov  = prb_r.cov + 1'b1;
          if (lnew <= 0) begin
            prb_run.act = 1'b0;
            if (lnew < 0) begin
              prb_run.trim  = 1'b1;
              prb_run.rv    = 1'b1;
              prb_run.rtop  = seg_r_r.top;
              prb_run.rspan = dim_t'(-lnew);
            end else begin
              prb_run.rneed = 1'b1;
            end
          end
        end
      end
    end else if (prb_r.v && prb_r.rneed) begin
      prb_run.rneed = 1'b0;
      if (seg_r_r.v) begin
        prb_run.rv    = 1'b1;
        prb_run.rtop  = seg_r_r.top;
        prb_run.rspan = seg_r_r.span;
      end
    end
  end

  always_comb begin
    xw             = {1'b0, seg_r_r.x} + {1'b0, ctl.w};
    prb_init       = '0;
    prb_init.v     = seg_r_r.v && (xw <= {1'b0, ctl.aw});
    prb_init.act   = 1'b1;
    prb_init.left  = $signed({1'b0, ctl.w});
    prb_init.y     = seg_r_r.top;
    prb_init.kx    = seg_r_r.x;
    prb_init.kspan = seg_r_r.span;
    prb_init.pv    = seg_l.v;
    prb_init.ptop  = seg_l.top;
  end

  always_comb begin
    unique case (ctl.op)
      OP_LAUNCH: prb_nxt = prb_init;
      OP_SCAN:   prb_nxt = prb_i;
      default:   prb_nxt = '0;
    endcase
  end

  // segment update: clear, insert shift, trim and merge, compaction swaps
  always_comb begin
    seg_nxt     = seg_r_r;
    end_x       = {1'b0, seg_r_r.x} + {1'b0, seg_r_r.span};
    sum_w       = ctl.w + (ctl.rmerge ? ctl.rspan : '0);
    left_member = ((IDX % 2) == 0) == (ctl.op == OP_SWAP_EVEN);
    unique case (ctl.op)
      OP_CLEAR: begin
        seg_nxt      = '0;
        seg_nxt.v    = (IDX == 0);
        seg_nxt.span = ctl.aw;
      end
      OP_INSERT: begin
        if (seg_l.v && (seg_l.x >= ctl.bx)) begin
          seg_nxt = seg_l;
        end else if (seg_r_r.v && (seg_r_r.x == ctl.bx)) begin
          seg_nxt.x    = ctl.bx;
          seg_nxt.top  = ctl.newtop;
          seg_nxt.span = ctl.w;
        end
      end
      OP_EDIT: begin
        if (seg_r_r.v) begin
          if (ctl.lmerge && (end_x == {1'b0, ctl.bx})) begin
            seg_nxt.span = seg_r_r.span + sum_w;
          end else if ((seg_r_r.x == ctl.bx) && (seg_r_r.top == ctl.newtop)) begin
            if (ctl.lmerge) seg_nxt.v = 1'b0;
            else seg_nxt.span = sum_w;
          end else if (seg_r_r.x >= ctl.bx) begin
            if (end_x <= {1'b0, ctl.edge_x}) begin
              seg_nxt.v = 1'b0;
            end else if (seg_r_r.x <= ctl.edge_x) begin
              if (ctl.rmerge) begin
                seg_nxt.v = 1'b0;
              end else begin
                seg_nxt.x    = ctl.edge_x;
                seg_nxt.span = dim_t'(end_x - {1'b0, ctl.edge_x});
              end
            end
          end
        end
      end
      OP_SWAP_EVEN, OP_SWAP_ODD: begin
        if (left_member) begin
          if (!seg_r_r.v && seg_r.v) seg_nxt = seg_r;
        end else begin
          // the first cell has no left partner
          if ((IDX != 0) && !seg_l.v && seg_r_r.v) seg_nxt = seg_l;
        end
      end
      default: seg_nxt = seg_r_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r_r      <= '0;
      seg_r_r.v    <= (IDX == 0);
      seg_r_r.span <= RESET_DIM;
      prb_r        <= '0;
    end else begin
      seg_r_r <= seg_nxt;
      prb_r   <= prb_nxt;
    end
  end

  assign seg_o = seg_r_r;
  assign prb_o = prb_run;

endmodule

FILE: sv/skyline_rect_packer_top.sv
// skyline bottom-left rectangle packer, top level with sequencer and cell chain
//
// input channel in_*: one item is a request (rect_width, rect_height), taken
//   whenever the block is idle, even while an earlier result still waits
// output channel out_*: one item per request (status, pos_x, pos_y, area_used),
//   held in an output register until the receiver takes it; while it stalls
//   the next request is accepted and worked on, and waits in the done state
// config channel cfg_*: index 0 atlas width, 1 atlas height; a write resets
//   the skyline to one segment and the area total to zero, other indexes ignored;
//   writes are taken only while the sequencer is idle
// the skyline lives in a chain of MAX_SEGMENTS cells; one probe per segment
//   start walks along the chain a cell per cycle, results leave at the far end
//   and a collector keeps the best; then an insert step, a trim/merge step
//   and an odd-even compaction sweep close the gaps
// the sequencer works on one request at a time
// reset: atlas 512 x 512, one segment spanning the width, area zero, no result
//   pending; no clearing sweep is needed
module skyline_rect_packer_top #(
  parameter int MAX_SEGMENTS = 256,
  parameter int MAX_DIM      = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // [12:0] rect_width, [25:13] rect_height, [31:26] zero
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] status, [13:2] pos_x, [25:14] pos_y, [50:26] area_used, [55:51] zero
  output logic [55:0] out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [srp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srp_pkg::DIM_W-1:0]     cfg_data
);
  import srp_pkg::*;

  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, count_r;
  dim_t   w_r, h_r, aw_r, ah_r;
  area_t  area_r;
  logic [PROD_W-1:0] prod_r;
  probe_t exit_r, bst_r;
  logic   found_r;
  status_t res_r;
  logic   out_v_r;
  status_t out_st_r;
  logic [POS_W-1:0] out_x_r, out_y_r;
  area_t  out_area_r;

  ctl_t   ctl;
  seg_t   segs [MAX_SEGMENTS];
  probe_t prbs [MAX_SEGMENTS];

  logic   in_acc, cfg_acc, cfg_clear, reject, cand, better;
  dim_t   cfg_dim, newtop;
  logic   lmerge, rmerge;
  logic [PROD_W-1:0] area_sum;

  // register value clamped to the legal range
  function automatic dim_t clamp_dim(input dim_t d);
    dim_t r;
    r = d;
    if (r == '0) r = dim_t'(1);
    if (int'(r) > MAX_DIM) r = dim_t'(MAX_DIM);
    return r;
  endfunction

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign cfg_clear = cfg_acc && ((cfg_index == REG_ATLAS_W) || (cfg_index == REG_ATLAS_H));
  assign cfg_dim   = clamp_dim(cfg_data);

  // request checks, in order: zero size, too large, store full
  assign reject = (w_r == '0) || (h_r == '0) || (w_r > aw_r) || (h_r > ah_r)
                  || (int'(count_r) >= MAX_SEGMENTS);

  assign newtop = bst_r.y + h_r;
  assign lmerge = bst_r.pv && (bst_r.ptop == newtop);
  assign rmerge = bst_r.rv && (bst_r.rtop == newtop);

  // collector: highest start exits first; y ties: smaller span, then lower one
  assign cand   = exit_r.v && !exit_r.act;
  assign better = !found_r || (exit_r.y < bst_r.y)
                  || ((exit_r.y == bst_r.y) && (exit_r.kspan <= bst_r.kspan));

  assign area_sum = PROD_W'(area_r) + prod_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_acc) state_nxt = S_LAUNCH;
      S_LAUNCH:  state_nxt = reject ? S_DONE : S_SCAN;
      S_SCAN:    if (int'(cnt_r) == MAX_SEGMENTS) state_nxt = S_INSERT;
      S_INSERT:  state_nxt = found_r ? S_EDIT : S_DONE;
      S_EDIT:    state_nxt = S_COMPACT;
      S_COMPACT: if (int'(cnt_r) == MAX_SEGMENTS - 1) state_nxt = S_DONE;
      S_DONE:    if (!out_v_r || out_tready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // broadcast to the chain
  always_comb begin
    ctl        = '0;
    ctl.w      = w_r;
    ctl.h      = h_r;
    ctl.aw     = aw_r;
    ctl.ah     = ah_r;
    ctl.bx     = bst_r.kx;
    ctl.newtop = newtop;
    ctl.edge_x = bst_r.kx + w_r;
    ctl.rspan  = bst_r.rspan;
    ctl.lmerge = lmerge;
    ctl.rmerge = rmerge;
    ctl.op     = OP_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_clear) begin
          ctl.op = OP_CLEAR;
          ctl.aw = (cfg_index == REG_ATLAS_W) ? cfg_dim : aw_r;
        end
      end
      S_LAUNCH:  ctl.op = reject ? OP_HOLD : OP_LAUNCH;
      S_SCAN:    ctl.op = OP_SCAN;
      S_INSERT:  ctl.op = found_r ? OP_INSERT : OP_HOLD;
      S_EDIT:    ctl.op = OP_EDIT;
      S_COMPACT: ctl.op = cnt_r[0] ? OP_SWAP_ODD : OP_SWAP_EVEN;
      default:   ctl.op = OP_HOLD;
    endcase
  end

  // the cell chain
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    seg_t   sl, sr;
    probe_t pi;
    if (i == 0) begin : g_first
      assign sl = '0;
      assign pi = '0;
    end else begin : g_mid
      assign sl = segs[i-1];
      assign pi = prbs[i-1];
    end
    if (i == MAX_SEGMENTS - 1) begin : g_last
      assign sr = '0;
    end else begin : g_inner
      assign sr = segs[i+1];
    end
    srp_cell #(.IDX(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .seg_l (sl),
      .seg_r (sr),
      .seg_o (segs[i]),
      .prb_i (pi),
      .prb_o (prbs[i])
    );
  end

  always_ff @(posedge clk) begin
    prod_r <= w_r * h_r;
    if (in_acc) begin
      w_r <= in_tdata[DIM_W-1:0];
      h_r <= in_tdata[2*DIM_W-1:DIM_W];
    end
    if (state_r == S_SCAN && cand && better) bst_r <= exit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      count_r    <= CW'(1);
      area_r     <= '0;
      aw_r       <= RESET_DIM;
      ah_r       <= RESET_DIM;
      exit_r     <= '0;
      found_r    <= 1'b0;
      res_r      <= ST_NOFIT;
      out_v_r    <= 1'b0;
      out_st_r   <= ST_PLACED;
      out_x_r    <= '0;
      out_y_r    <= '0;
      out_area_r <= '0;
    end else begin
      state_r <= state_nxt;
      exit_r  <= (ctl.op == OP_SCAN) ? prbs[MAX_SEGMENTS-1] : '0;

      if (cfg_acc) begin
        if (cfg_index == REG_ATLAS_W) aw_r <= cfg_dim;
        if (cfg_index == REG_ATLAS_H) ah_r <= cfg_dim;
        if (cfg_clear) begin
          count_r <= CW'(1);
          area_r  <= '0;
        end
      end

      unique case (state_r)
        S_LAUNCH: begin
          cnt_r   <= '0;
          found_r <= 1'b0;
          if ((w_r == '0) || (h_r == '0)) res_r <= ST_ZERO;
          else if ((w_r > aw_r) || (h_r > ah_r)) res_r <= ST_NOFIT;
          else res_r <= ST_FULL;
        end
        S_SCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cand && better) found_r <= 1'b1;
        end
        S_INSERT: begin
          if (found_r) begin
            res_r   <= ST_PLACED;
            area_r  <= (area_sum > PROD_W'(AREA_MAX)) ? AREA_MAX : area_sum[AREA_W-1:0];
            count_r <= CW'(int'(count_r) + 1 - int'(bst_r.cov) + int'(bst_r.trim)
                           - int'(lmerge) - int'(rmerge));
          end else begin
            res_r <= ST_NOFIT;
          end
        end
        S_EDIT:    cnt_r <= '0;
        S_COMPACT: cnt_r <= cnt_r + 1'b1;
        default: ;
      endcase

      // output register, loaded once the previous result is gone
      if (state_r == S_DONE && (!out_v_r || out_tready)) begin
        out_v_r    <= 1'b1;
        out_st_r   <= res_r;
        out_x_r    <= (res_r == ST_PLACED) ? bst_r.kx[POS_W-1:0] : '0;
        out_y_r    <= (res_r == ST_PLACED) ? bst_r.y[POS_W-1:0] : '0;
        out_area_r <= area_r;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, out_area_r, out_y_r, out_x_r, out_st_r};

  `include "skyline_rect_packer_top_assert.svh"

  `SRP_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, (count_r != '0) && (int'(count_r) <= MAX_SEGMENTS), "segment count out of range")
  `SRP_ASSERT_IMP(a_exit_in_scan, clk, rst_n, exit_r.v, state_r == S_SCAN, "probe left the chain outside the scan")
  `SRP_ASSERT_NXT(a_area_grows, clk, rst_n, state_r == S_INSERT, area_r >= $past(area_r), "area total went down")

endmodule

FILE: sim/skyline_rect_packer_top_tb.sv
// self-checking testbench of the skyline rectangle packer: random and directed requests
module skyline_rect_packer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srp_pkg::*;

  localparam int SEGS = 256;
  localparam int DIM_LIMIT = 4096;
  localparam int LIMIT_CYCLES = 3000000;

  typedef struct packed {
    logic [12:0] w;
    logic [12:0] h;
  } request_t;

  // packed from the top bit down, so status lands in the lowest bits
  typedef struct packed {
    logic [24:0] area;
    logic [11:0] py;
    logic [11:0] px;
    status_t     status;
  } placement_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [31:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DIM_W-1:0] cfg_data = '0;

  skyline_rect_packer_top dut (.*);

  // predictor state: the skyline and the atlas size
  int sky_x[SEGS + 1], sky_top[SEGS + 1], sky_span[SEGS + 1];
  int sky_n;
  int atlas_w, atlas_h;
  longint area_sum;

  request_t   pending_items[$];
  placement_t expected_results[$];
  int  send_idle_pct = 0, recv_stall_pct = 0;
  bit  hold_off = 1'b0;
  int  fail_count = 0;
  longint cycle_count = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic void clear_skyline();
    for (int i = 0; i <= SEGS; i++) begin
      sky_x[i] = 0; sky_top[i] = 0; sky_span[i] = 0;
    end
    sky_span[0] = atlas_w;
    sky_n = 1;
    area_sum = 0;
  endfunction

  function automatic int clamp_dim(int v);
    if (v == 0) return 1;
    if (v > DIM_LIMIT) return DIM_LIMIT;
    return v;
  endfunction

  function automatic void drop_seg(int k);
    for (int j = k; j + 1 < sky_n; j++) begin
      sky_x[j] = sky_x[j+1]; sky_top[j] = sky_top[j+1]; sky_span[j] = sky_span[j+1];
    end
    sky_n--;
  endfunction

  // lowest resting y with the left edge on segment k, or -1
  function automatic int resting_y(int k, int w, int h);
    int rem, y, i;
    rem = w; y = sky_top[k]; i = k;
    if (sky_x[k] + w > atlas_w) return -1;
    while (rem > 0) begin
      if (i >= sky_n) return -1;
      if (sky_top[i] > y) y = sky_top[i];
      if (y + h > atlas_h) return -1;
      rem -= sky_span[i];
      i++;
    end
    return y;
  endfunction

  function automatic void insert_level(int k, int x, int y, int w, int h);
    int i, edge_x;
    for (int j = sky_n; j > k; j--) begin
      sky_x[j] = sky_x[j-1]; sky_top[j] = sky_top[j-1]; sky_span[j] = sky_span[j-1];
    end
    sky_x[k] = x; sky_top[k] = y + h; sky_span[k] = w;
    sky_n++;
    i = k + 1;
    while (i < sky_n) begin
      edge_x = sky_x[i-1] + sky_span[i-1];
      if (sky_x[i] < edge_x) begin
        sky_span[i] -= edge_x - sky_x[i];
        sky_x[i] = edge_x;
        if (sky_span[i] <= 0) drop_seg(i);
        else break;
      end else break;
    end
    i = 0;
    while (i + 1 < sky_n) begin
      if (sky_top[i] == sky_top[i+1]) begin
        sky_span[i] += sky_span[i+1];
        drop_seg(i + 1);
      end else i++;
    end
  endfunction

  function automatic placement_t pack_rect(request_t r);
    placement_t p;
    int w, h, y, best_span, best_y, best_x, best_k;
    bit found;
    w = r.w; h = r.h;
    p = '{status: ST_NOFIT, px: '0, py: '0, area: '0};
    if (w == 0 || h == 0) p.status = ST_ZERO;
    else if (w > atlas_w || h > atlas_h) p.status = ST_NOFIT;
    else if (sky_n >= SEGS) p.status = ST_FULL;
    else begin
      best_span = atlas_w + 1; best_y = atlas_h + 1; best_x = 0; best_k = 0;
      found = 1'b0;
      for (int k = 0; k < sky_n; k++) begin
        y = resting_y(k, w, h);
        if (y < 0) continue;
        if (y < best_y || (y == best_y && sky_span[k] < best_span)) begin
          found = 1'b1; best_k = k; best_span = sky_span[k];
          best_x = sky_x[k]; best_y = y;
        end
      end
      if (found) begin
        insert_level(best_k, best_x, best_y, w, h);
        area_sum += w * h;
        if (area_sum > 33554431) area_sum = 33554431;
        p.status = ST_PLACED;
        p.px = best_x[11:0];
        p.py = best_y[11:0];
      end
    end
    p.area = area_sum[24:0];
    return p;
  endfunction

  // driver: offers items from the queue of pending requests
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tdata  <= {6'd0, pending_items[0].h, pending_items[0].w};
          in_tvalid <= 1'b1;
          expected_results.push_back(pack_rect(pending_items.pop_front()));
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compares every taken result with the oldest expectation
  always @(posedge clk) begin
    placement_t got, want;
    if (rst_n) begin
      out_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
      if (out_tvalid && out_tready) begin
        got = out_tdata[50:0];
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding: %h", got);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); fail_count++;
          end
          if (got.px !== want.px) begin
            $error("pos_x exp %0d got %0d", want.px, got.px); fail_count++;
          end
          if (got.py !== want.py) begin
            $error("pos_y exp %0d got %0d", want.py, got.py); fail_count++;
          end
          if (got.area !== want.area) begin
            $error("area_used exp %0d got %0d", want.area, got.area); fail_count++;
          end
        end
      end
    end
  end

  // wait for the pipe to drain, then let any late work settle
  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // register write while idle; the predictor follows
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_index <= idx;
    cfg_data  <= val[DIM_W-1:0];
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ATLAS_W) atlas_w = clamp_dim(val & 13'h1fff);
    else if (idx == REG_ATLAS_H) atlas_h = clamp_dim(val & 13'h1fff);
    if (idx == REG_ATLAS_W || idx == REG_ATLAS_H) clear_skyline();
  endtask

  function automatic void add_req(int w, int h);
    request_t r;
    r.w = w[12:0]; r.h = h[12:0];
    pending_items.push_back(r);
  endfunction

  // mostly sizes that fit the atlas, some zero, oversize and full-range values
  function automatic void add_random(int n);
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(99);
      if (c < 75) add_req($urandom_range(1, (atlas_w + 3) / 4), $urandom_range(1, (atlas_h + 3) / 4));
      else if (c < 85) add_req($urandom_range(1, 6), $urandom_range(1, 6));
      else if (c < 90) add_req($urandom_range(0, 1), $urandom_range(0, 8191));
      else add_req($urandom_range(0, 8191), $urandom_range(0, 8191));
    end
  endfunction

  initial begin
    atlas_w = 512; atlas_h = 512;
    clear_skyline();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero sizes, oversize, full atlas, exact fits, ties
    add_req(0, 5); add_req(5, 0); add_req(0, 0); add_req(513, 1); add_req(1, 513);
    add_req(8191, 8191); add_req(100, 50); add_req(100, 50); add_req(50, 100);
    add_req(312, 50); add_req(512, 1); add_req(512, 512); add_req(1, 1);
    drain();

    // smallest atlas and clamping of zero, then walk the store to full
    write_reg(REG_ATLAS_W, 0);
    write_reg(REG_ATLAS_H, 8191);
    add_req(1, 4096); add_req(1, 1); add_req(2, 1);
    drain();
    write_reg(REG_ATLAS_W, 4096);
    write_reg(REG_ATLAS_H, 4096);
    add_req(4096, 4096); add_req(1, 1);
    drain();
    write_reg(REG_ATLAS_H, 300);
    // staircase of shrinking heights to fill the segment store
    for (int i = 0; i < 260; i++) add_req(1, 290 - i);
    add_req(1, 1); add_req(4000, 1);
    drain();

    // random phases with varied idling and atlas sizes
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_ATLAS_W, (ph == 0) ? 512 : $urandom_range(16, 1024));
      write_reg(REG_ATLAS_H, (ph == 3) ? 4096 : $urandom_range(16, 1024));
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      add_random(100);
      drain();
    end

    // long receiver hold-off while requests keep coming
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_off = 1'b1;
    add_random(40);
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
    drain();
    add_random(60);
    drain();

    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
